[rtl/lob_pkg.sv]
// shared types, codes and constants of the limit order book
package lob_pkg;

    // default geometry of the book
    localparam int TICKERS_DEF          = 4;
    localparam int PRICE_LEVELS_DEF     = 1024;
    localparam int ORDERS_PER_LEVEL_DEF = 16;

    // fixed field widths
    localparam int ID_WIDTH  = 16;
    localparam int OP_W      = 2;
    localparam int TICKER_W  = 2;
    localparam int PRICE_W   = 10;
    localparam int STATUS_W  = 3;

    // occupancy marks are stored as words of this many levels
    localparam int OCC_W     = 32;
    localparam int OCC_BIT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD,
        OP_FULFIL,
        OP_QUERY,
        OP_NONE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_NOCROSS,
        ST_FULL,
        ST_NOTFOUND
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC,
        S_RDCNT,
        S_ADD,
        S_F_RD,
        S_F_CMP,
        S_SH_RD,
        S_SH_WR,
        S_F_END,
        S_QRD,
        S_QCHK,
        S_QCMP,
        S_FIN
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load_in;
        logic    clr_step;
        logic    cnt_rd;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    occ_rd_lvl;
        logic    occ_rd_scan;
        logic    occ_set;
        logic    occ_clr;
        logic    cap_count;
        logic    idx_clr;
        logic    idx_inc;
        logic    q_rd_idx;
        logic    q_rd_next;
        logic    q_wr_add;
        logic    q_wr_shift;
        logic    ptr_init;
        logic    ptr_step;
        logic    best_load;
        logic    stat_load;
        logic    best_keep;
        status_t stat_code;
        logic    out_load;
    } lob_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_done;
        op_t  op;
        logic in_book;
        logic ticker_ok;
        logic count_full;
        logic idx_at_count;
        logic next_at_count;
        logic count_one;
        logic match;
        logic scan_hit;
        logic scan_last;
        logic cross_ok;
    } lob_sts_t;

endpackage

[rtl/lob_ctrl.sv]
// controller state machine of the limit order book
module lob_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lob_pkg::lob_cmd_t cmd,
    input  lob_pkg::lob_sts_t sts
);
    import lob_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // state and result valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        cmd            = '0;
        cmd.stat_code  = ST_OK;
        state_next     = state_reg;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = !sts.clr_done;
                if (sts.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (sts.op)
                    OP_ADD, OP_FULFIL:
                    begin
                        if (!sts.in_book)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = (sts.op == OP_ADD) ? ST_FULL : ST_NOTFOUND;
                            state_next    = S_FIN;
                        end
                        else
                        begin
                            cmd.cnt_rd     = 1'b1;
                            cmd.occ_rd_lvl = 1'b1;
                            state_next     = S_RDCNT;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (!sts.ticker_ok)
                        begin
                            cmd.stat_load = 1'b1;
                            cmd.stat_code = ST_EMPTY;
                            state_next    = S_FIN;
                        end
                        else
                        begin
                            cmd.ptr_init = 1'b1;
                            state_next   = S_QRD;
                        end
                    end
                    OP_NONE:
                    begin
                        cmd.stat_load = 1'b1;
                        cmd.stat_code = ST_OK;
                        state_next    = S_FIN;
                    end
                endcase
            end
            S_RDCNT:
            begin
                cmd.cap_count = 1'b1;
                state_next    = (sts.op == OP_ADD) ? S_ADD : S_F_RD;
            end
            S_ADD:
            begin
                cmd.stat_load = 1'b1;
                if (sts.count_full)
                    cmd.stat_code = ST_FULL;
                else
                begin
                    cmd.q_wr_add  = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    cmd.occ_set   = 1'b1;
                    cmd.stat_code = ST_OK;
                end
                state_next = S_FIN;
            end
            S_F_RD:
            begin
                if (sts.idx_at_count)
                begin
                    cmd.stat_load = 1'b1;
                    cmd.stat_code = ST_NOTFOUND;
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.q_rd_idx = 1'b1;
                    state_next   = S_F_CMP;
                end
            end
            S_F_CMP:
            begin
                if (sts.match)
                    state_next = S_SH_RD;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_F_RD;
                end
            end
            S_SH_RD:
            begin
                if (sts.next_at_count)
                    state_next = S_F_END;
                else
                begin
                    cmd.q_rd_next = 1'b1;
                    state_next    = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.q_wr_shift = 1'b1;
                cmd.idx_inc    = 1'b1;
                state_next     = S_SH_RD;
            end
            S_F_END:
            begin
                cmd.cnt_dec   = 1'b1;
                cmd.occ_clr   = sts.count_one;
                cmd.stat_load = 1'b1;
                cmd.stat_code = ST_OK;
                state_next    = S_FIN;
            end
            S_QRD:
            begin
                cmd.occ_rd_scan = 1'b1;
                state_next      = S_QCHK;
            end
            S_QCHK:
            begin
                if (sts.scan_hit)
                begin
                    cmd.best_load = 1'b1;
                    state_next    = S_QCMP;
                end
                else if (sts.scan_last)
                begin
                    cmd.stat_load = 1'b1;
                    cmd.stat_code = ST_EMPTY;
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.ptr_step = 1'b1;
                    state_next   = S_QRD;
                end
            end
            S_QCMP:
            begin
                cmd.stat_load = 1'b1;
                cmd.best_keep = sts.cross_ok;
                cmd.stat_code = sts.cross_ok ? ST_OK : ST_NOCROSS;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/lob_dp.sv]
// datapath of the limit order book: level queues, counts, occupancy words
module lob_dp #(
    parameter int TICKERS          = lob_pkg::TICKERS_DEF,
    parameter int PRICE_LEVELS     = lob_pkg::PRICE_LEVELS_DEF,
    parameter int ORDERS_PER_LEVEL = lob_pkg::ORDERS_PER_LEVEL_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lob_pkg::lob_cmd_t             cmd,
    output lob_pkg::lob_sts_t             sts,
    input  logic [lob_pkg::OP_W-1:0]      operation,
    input  logic [lob_pkg::TICKER_W-1:0]  ticker,
    input  logic                          side,
    input  logic [lob_pkg::PRICE_W-1:0]   price,
    input  logic [lob_pkg::ID_WIDTH-1:0]  order_id,
    output logic [lob_pkg::STATUS_W-1:0]  status,
    output logic [lob_pkg::PRICE_W-1:0]   best_price
);
    import lob_pkg::*;

    localparam int BOOKS      = TICKERS * 2;
    localparam int NUM_LEVELS = BOOKS * PRICE_LEVELS;
    localparam int LW         = $clog2(NUM_LEVELS);
    localparam int CLW        = $clog2(NUM_LEVELS + 1);
    localparam int WPB        = (PRICE_LEVELS + OCC_W - 1) / OCC_W;
    localparam int PTRW       = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int OCC_WORDS  = BOOKS * WPB;
    localparam int OAW        = $clog2(OCC_WORDS);
    localparam int QDEPTH     = NUM_LEVELS * ORDERS_PER_LEVEL;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int CW         = $clog2(ORDERS_PER_LEVEL + 1);
    localparam int PW         = $clog2(PRICE_LEVELS);
    localparam int FW         = PTRW + OCC_BIT_W;
    localparam int BW         = $clog2(BOOKS);
    localparam int CMPW       = ((FW > PRICE_W) ? FW : PRICE_W) + 1;

    // captured item
    op_t                 op_reg;
    logic [TICKER_W-1:0] tick_reg;
    logic                side_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic [ID_WIDTH-1:0] id_reg;

    // working registers
    logic [CLW-1:0]      clr_idx_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       idx_reg;
    logic [PTRW-1:0]     ptr_reg;
    logic [PW-1:0]       best_reg;
    status_t             stat_reg;
    status_t             out_status_reg;
    logic [PRICE_W-1:0]  out_best_reg;

    // memories and their registered read data
    logic [ID_WIDTH-1:0] q_mem   [QDEPTH];
    logic [CW-1:0]       cnt_mem [NUM_LEVELS];
    logic [OCC_W-1:0]    occ_mem [OCC_WORDS];
    logic [ID_WIDTH-1:0] q_rdata_reg;
    logic [CW-1:0]       cnt_rdata_reg;
    logic [OCC_W-1:0]    occ_rdata_reg;

    // address arithmetic
    logic [BW-1:0]       own_book;
    logic [BW-1:0]       opp_book;
    logic [31:0]         lvl_full;
    logic [LW-1:0]       lvl_addr;
    logic [31:0]         occ_lvl_full;
    logic [31:0]         occ_scan_full;
    logic [OAW-1:0]      occ_raddr;
    logic [CW-1:0]       q_rslot;
    logic [CW-1:0]       q_wslot;
    logic [31:0]         q_raddr_full;
    logic [31:0]         q_waddr_full;
    logic [OCC_BIT_W-1:0] bit_pos;
    logic [OCC_W-1:0]    bit_mask;

    // write ports
    logic                cnt_we;
    logic [LW-1:0]       cnt_waddr;
    logic [CW-1:0]       cnt_wdata;
    logic                occ_we;
    logic [OAW-1:0]      occ_waddr;
    logic [OCC_W-1:0]    occ_wdata;
    logic                q_we;
    logic [ID_WIDTH-1:0] q_wdata;

    // scan result
    logic [OCC_BIT_W-1:0] scan_pos;
    logic [FW-1:0]        found;

    assign own_book = BW'(32'(tick_reg) * 32'd2 + 32'(side_reg));
    assign opp_book = BW'(32'(tick_reg) * 32'd2 + 32'(!side_reg));
    assign lvl_full = 32'(own_book) * 32'(PRICE_LEVELS) + 32'(price_reg);
    assign lvl_addr = lvl_full[LW-1:0];
    assign bit_pos  = price_reg[OCC_BIT_W-1:0];
    assign bit_mask = OCC_W'(1) << bit_pos;

    assign occ_lvl_full  = 32'(own_book) * 32'(WPB) + 32'(price_reg >> OCC_BIT_W);
    assign occ_scan_full = 32'(opp_book) * 32'(WPB) + 32'(ptr_reg);
    assign occ_raddr     = cmd.occ_rd_scan ? occ_scan_full[OAW-1:0] : occ_lvl_full[OAW-1:0];

    assign q_rslot      = cmd.q_rd_next ? (idx_reg + CW'(1)) : idx_reg;
    assign q_wslot      = cmd.q_wr_add ? count_reg : idx_reg;
    assign q_raddr_full = 32'(lvl_addr) * 32'(ORDERS_PER_LEVEL) + 32'(q_rslot);
    assign q_waddr_full = 32'(lvl_addr) * 32'(ORDERS_PER_LEVEL) + 32'(q_wslot);

    // write port selection
    always_comb
    begin
        cnt_we    = cmd.clr_step || cmd.cnt_inc || cmd.cnt_dec;
        cnt_waddr = cmd.clr_step ? clr_idx_reg[LW-1:0] : lvl_addr;
        cnt_wdata = cmd.clr_step ? '0 :
                    (cmd.cnt_inc ? count_reg + CW'(1) : count_reg - CW'(1));

        occ_we    = (cmd.clr_step && (clr_idx_reg < CLW'(OCC_WORDS)))
                    || cmd.occ_set || cmd.occ_clr;
        occ_waddr = cmd.clr_step ? clr_idx_reg[OAW-1:0] : occ_lvl_full[OAW-1:0];
        occ_wdata = cmd.clr_step ? '0 :
                    (cmd.occ_set ? (occ_rdata_reg | bit_mask) : (occ_rdata_reg & ~bit_mask));

        q_we      = cmd.q_wr_add || cmd.q_wr_shift;
        q_wdata   = cmd.q_wr_add ? id_reg : q_rdata_reg;
    end

    // level count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cmd.cnt_rd)
            cnt_rdata_reg <= cnt_mem[lvl_addr];
    end

    // occupancy word memory
    always_ff @(posedge clk)
    begin
        if (occ_we)
            occ_mem[occ_waddr] <= occ_wdata;
        if (cmd.occ_rd_lvl || cmd.occ_rd_scan)
            occ_rdata_reg <= occ_mem[occ_raddr];
    end

    // order id queue memory
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_waddr_full[QAW-1:0]] <= q_wdata;
        if (cmd.q_rd_idx || cmd.q_rd_next)
            q_rdata_reg <= q_mem[q_raddr_full[QAW-1:0]];
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_idx_reg <= '0;
        else if (cmd.clr_step)
            clr_idx_reg <= clr_idx_reg + CLW'(1);
    end

    // lowest set bit for a buy query, highest for a sell query
    always_comb
    begin
        scan_pos = '0;
        if (!side_reg)
        begin
            for (int i = OCC_W - 1; i >= 0; i--)
                if (occ_rdata_reg[i])
                    scan_pos = OCC_BIT_W'(i);
        end
        else
        begin
            for (int i = 0; i < OCC_W; i++)
                if (occ_rdata_reg[i])
                    scan_pos = OCC_BIT_W'(i);
        end
    end

    assign found = {ptr_reg, scan_pos};

    // item capture, slot index, scan pointer, results
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= op_t'(operation);
            tick_reg  <= ticker;
            side_reg  <= side;
            price_reg <= price;
            id_reg    <= order_id;
        end
        if (cmd.cap_count)
            count_reg <= cnt_rdata_reg;
        if (cmd.idx_clr)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + CW'(1);
        if (cmd.ptr_init)
            ptr_reg <= side_reg ? PTRW'(WPB - 1) : '0;
        else if (cmd.ptr_step)
            ptr_reg <= side_reg ? ptr_reg - PTRW'(1) : ptr_reg + PTRW'(1);
        if (cmd.best_load)
            best_reg <= found[PW-1:0];
        else if (cmd.stat_load && !cmd.best_keep)
            best_reg <= '0;
        if (cmd.stat_load)
            stat_reg <= cmd.stat_code;
        if (cmd.out_load)
        begin
            out_status_reg <= stat_reg;
            out_best_reg   <= PRICE_W'(best_reg);
        end
    end

    // status toward the controller
    always_comb
    begin
        sts.clr_done      = (clr_idx_reg == CLW'(NUM_LEVELS));
        sts.op            = op_reg;
        sts.ticker_ok     = (32'(tick_reg) < 32'(TICKERS));
        sts.in_book       = sts.ticker_ok && (32'(price_reg) < 32'(PRICE_LEVELS));
        sts.count_full    = (count_reg >= CW'(ORDERS_PER_LEVEL));
        sts.idx_at_count  = (idx_reg == count_reg);
        sts.next_at_count = ((idx_reg + CW'(1)) == count_reg);
        sts.count_one     = (count_reg == CW'(1));
        sts.match         = (q_rdata_reg == id_reg);
        sts.scan_hit      = |occ_rdata_reg;
        sts.scan_last     = side_reg ? (ptr_reg == '0) : (ptr_reg == PTRW'(WPB - 1));
        sts.cross_ok      = side_reg ? (CMPW'(best_reg) >= CMPW'(price_reg))
                                     : (CMPW'(best_reg) <= CMPW'(price_reg));
    end

    assign status     = out_status_reg;
    assign best_price = out_best_reg;

endmodule

[rtl/limit_order_book_core.sv]
// top level of the limit order book: controller, datapath and result register
// One item at a time. After reset a clearing pass over TICKERS*2*PRICE_LEVELS
// level counts (8192 by default) zeroes them and the occupancy words; no
// item is taken until it ends. An add reads the level count and occupancy
// word, then, unless the level is full, writes the queue entry, the count and
// the occupancy word; a fulfil compares the queue entries one by one and,
// when the id is found, shifts each later entry down; a query scans the
// opposite side's 32-level occupancy words one at a time from its best end.
// Each memory has a single read port whose data is registered before it is
// examined. The result sits in an output register; the next item is taken
// while it waits.
module limit_order_book_core #(
    parameter int TICKERS          = lob_pkg::TICKERS_DEF,
    parameter int PRICE_LEVELS     = lob_pkg::PRICE_LEVELS_DEF,
    parameter int ORDERS_PER_LEVEL = lob_pkg::ORDERS_PER_LEVEL_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lob_pkg::OP_W-1:0]      operation,
    input  logic [lob_pkg::TICKER_W-1:0]  ticker,
    input  logic                          side,
    input  logic [lob_pkg::PRICE_W-1:0]   price,
    input  logic [lob_pkg::ID_WIDTH-1:0]  order_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lob_pkg::STATUS_W-1:0]  status,
    output logic [lob_pkg::PRICE_W-1:0]   best_price
);
    import lob_pkg::*;

    lob_cmd_t cmd;
    lob_sts_t sts;

    // sequencer
    lob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // book storage and arithmetic
    lob_dp #(
        .TICKERS          (TICKERS),
        .PRICE_LEVELS     (PRICE_LEVELS),
        .ORDERS_PER_LEVEL (ORDERS_PER_LEVEL)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (operation),
        .ticker     (ticker),
        .side       (side),
        .price      (price),
        .order_id   (order_id),
        .status     (status),
        .best_price (best_price)
    );

endmodule

[rtl/lob_checker.sv]
// port-level assertions of the limit order book, bound to the top level
module lob_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [lob_pkg::STATUS_W-1:0]  status,
    input logic [lob_pkg::PRICE_W-1:0]   best_price
);
    import lob_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(best_price))
        else $error("result changed while stalled");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= STATUS_W'(ST_NOTFOUND)))
        else $error("undefined status code");

    // a price is reported only with an ok status
    a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_W'(ST_OK)) |-> (best_price == '0))
        else $error("price reported with error status");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

endmodule

bind limit_order_book_core lob_checker u_lob_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .best_price (best_price)
);

[sim/testbench.sv]
// testbench of limit_order_book_core: directed and random order traffic checked against a book model
module testbench;
    import lob_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLEVELS    = 4 * 2 * 1024;
    localparam int DEPTH      = 16;
    localparam int CYCLE_CAP  = 1500000;
    localparam int RND_ITEMS  = 1800;

    typedef struct {
        status_t    st;
        logic [9:0] best;
    } book_answer_t;

    typedef struct {
        logic [1:0]  tk;
        logic        sd;
        logic [9:0]  px;
        logic [15:0] id;
    } resting_order_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic [1:0]  ticker = '0;
    logic        side = 1'b0;
    logic [9:0]  price = '0;
    logic [15:0] order_id = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [9:0]  best_price;

    // book copy used for prediction
    logic [15:0] book_ids [NLEVELS][DEPTH];
    int          book_cnt [NLEVELS];
    bit          book_occ [NLEVELS];

    book_answer_t   pending_answers[$];
    resting_order_t resting[$];
    int             errors = 0;
    int             hold_cycles = 0;
    longint         cycles = 0;

    limit_order_book_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .ticker     (ticker),
        .side       (side),
        .price      (price),
        .order_id   (order_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .best_price (best_price)
    );

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("limit_order_book_core: mismatch");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // book behavior for one order message
    function automatic book_answer_t book_apply(op_t op, logic [1:0] tk, logic sd,
                                                logic [9:0] px, logic [15:0] id);
        book_answer_t a;
        int lvl;
        int n;
        int base;
        a.st = ST_OK;
        a.best = '0;
        lvl = int'({tk, sd, px});
        n = book_cnt[lvl];
        case (op)
            OP_ADD:
            begin
                if (n >= DEPTH)
                    a.st = ST_FULL;
                else
                begin
                    book_ids[lvl][n] = id;
                    book_cnt[lvl] = n + 1;
                    book_occ[lvl] = 1'b1;
                end
            end
            OP_FULFIL:
            begin
                a.st = ST_NOTFOUND;
                for (int i = 0; i < n; i++)
                begin
                    if (book_ids[lvl][i] == id)
                    begin
                        for (int j = i; j + 1 < n; j++)
                            book_ids[lvl][j] = book_ids[lvl][j + 1];
                        book_cnt[lvl] = n - 1;
                        if (n == 1)
                            book_occ[lvl] = 1'b0;
                        a.st = ST_OK;
                        break;
                    end
                end
            end
            OP_QUERY:
            begin
                a.st = ST_EMPTY;
                // buy looks at lowest sell, sell at highest buy
                base = int'({tk, ~sd, 10'd0});
                if (!sd)
                begin
                    for (int p = 0; p < 1024; p++)
                        if (book_occ[base + p])
                        begin
                            if (p > px)
                                a.st = ST_NOCROSS;
                            else
                            begin
                                a.st = ST_OK;
                                a.best = 10'(p);
                            end
                            break;
                        end
                end
                else
                begin
                    for (int p = 1023; p >= 0; p--)
                        if (book_occ[base + p])
                        begin
                            if (p < px)
                                a.st = ST_NOCROSS;
                            else
                            begin
                                a.st = ST_OK;
                                a.best = 10'(p);
                            end
                            break;
                        end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // one transfer on the input side, expectation recorded at acceptance
    task automatic send_order(op_t op, logic [1:0] tk, logic sd, logic [9:0] px,
                              logic [15:0] id, output status_t st);
        book_answer_t a;
        @(negedge clk);
        operation = op;
        ticker = tk;
        side = sd;
        price = px;
        order_id = id;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        a = book_apply(op, tk, sd, px, id);
        pending_answers = {pending_answers, a};
        st = a.st;
    endtask

    task automatic idle_input(int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // stop offering, then wait for every expected result
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // receiver side: random stalls, or a forced hold-off
    initial
    begin
        int g;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else
            begin
                g = gap_len();
                if (g == 0)
                    out_ready = 1'b1;
                else
                begin
                    out_ready = 1'b0;
                    repeat (g - 1)
                    begin
                        @(negedge clk);
                        if (hold_cycles > 0)
                            hold_cycles--;
                    end
                end
            end
        end
    end

    // result check on each output transfer
    always @(posedge clk)
    begin
        book_answer_t a;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result with no expectation: status %0d", status);
                errors++;
            end
            else
            begin
                a = pending_answers.pop_front();
                if (status !== a.st)
                begin
                    $error("status expected %0d actual %0d", a.st, status);
                    errors++;
                end
                if (best_price !== a.best)
                begin
                    $error("best_price expected %0d actual %0d", a.best, best_price);
                    errors++;
                end
            end
        end
    end

    // extreme prices and ids, queries on both sides
    task automatic test_extremes();
        status_t st;
        send_order(OP_QUERY, 2'd0, 1'b0, 10'd512, 16'h0000, st);
        send_order(OP_ADD, 2'd0, 1'b1, 10'd1023, 16'hFFFF, st);
        send_order(OP_ADD, 2'd0, 1'b0, 10'd0, 16'h0000, st);
        send_order(OP_QUERY, 2'd0, 1'b0, 10'd1023, 16'h0000, st);
        send_order(OP_QUERY, 2'd0, 1'b0, 10'd1022, 16'h0000, st);
        send_order(OP_QUERY, 2'd0, 1'b1, 10'd0, 16'h0000, st);
        send_order(OP_QUERY, 2'd0, 1'b1, 10'd1, 16'h0000, st);
        send_order(OP_FULFIL, 2'd0, 1'b1, 10'd1023, 16'h1234, st);
        send_order(OP_FULFIL, 2'd0, 1'b1, 10'd1023, 16'hFFFF, st);
        send_order(OP_FULFIL, 2'd0, 1'b0, 10'd0, 16'h0000, st);
        send_order(OP_NONE, 2'd3, 1'b1, 10'h3FF, 16'hFFFF, st);
        send_order(OP_QUERY, 2'd3, 1'b1, 10'd0, 16'h0000, st);
        drain();
    endtask

    // fill a level past capacity with a duplicate id, then fulfil that id, oldest copy first, until none is left
    task automatic test_level_full();
        status_t st;
        for (int i = 0; i < DEPTH; i++)
            send_order(OP_ADD, 2'd2, 1'b0, 10'd300, (i == 5) ? 16'd7 : 16'(i), st);
        send_order(OP_ADD, 2'd2, 1'b0, 10'd300, 16'd99, st);
        send_order(OP_FULFIL, 2'd2, 1'b0, 10'd300, 16'd7, st);
        send_order(OP_FULFIL, 2'd2, 1'b0, 10'd300, 16'd7, st);
        send_order(OP_FULFIL, 2'd2, 1'b0, 10'd300, 16'd7, st);
        send_order(OP_QUERY, 2'd2, 1'b1, 10'd300, 16'd0, st);
        drain();
    endtask

    // hold the output while items keep coming so the input stalls
    task automatic test_backpressure();
        status_t st;
        @(negedge clk);
        hold_cycles = 500;
        for (int i = 0; i < 12; i++)
            send_order(OP_QUERY, 2'(i), 1'(i), 10'($urandom), 16'($urandom), st);
        drain();
    endtask

    // random order flow concentrated on a few narrow price bands
    task automatic test_random();
        status_t        st;
        resting_order_t o;
        op_t            op;
        int             r;
        int             k;
        logic [9:0]     band [4];
        band[0] = 10'd0;
        band[1] = 10'd1016;
        band[2] = 10'($urandom_range(100, 900));
        band[3] = 10'($urandom_range(100, 900));
        for (int n = 0; n < RND_ITEMS; n++)
        begin
            r = $urandom_range(0, 99);
            o.tk = 2'($urandom);
            o.sd = 1'($urandom);
            o.px = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                   : band[$urandom_range(0, 3)] + 10'($urandom_range(0, 7));
            o.id = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            if (r < 40)
                op = OP_ADD;
            else if (r < 72)
            begin
                op = OP_FULFIL;
                if (resting.size() != 0 && $urandom_range(0, 9) != 0)
                begin
                    k = $urandom_range(0, resting.size() - 1);
                    o = resting[k];
                    resting.delete(k);
                end
            end
            else if (r < 96)
                op = OP_QUERY;
            else
                op = OP_NONE;
            send_order(op, o.tk, o.sd, o.px, o.id, st);
            if (op == OP_ADD && st == ST_OK)
                resting = {resting, o};
            idle_input(gap_len());
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < NLEVELS; i++)
        begin
            book_cnt[i] = 0;
            book_occ[i] = 1'b0;
        end
        test_extremes();
        test_level_full();
        test_backpressure();
        test_random();
        idle_input(1);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("limit_order_book_core: match");
        else
            $display("limit_order_book_core: mismatch");
        $finish;
    end

endmodule

[files.f]
rtl/lob_pkg.sv
rtl/lob_ctrl.sv
rtl/lob_dp.sv
rtl/limit_order_book_core.sv
rtl/lob_checker.sv
sim/testbench.sv
